@@ hdl/rwc_pkg.sv @@
package rwc_pkg;

	localparam int VALUE_BITS = 64;
	localparam int CFG_DATA_BITS = 64;
	localparam int REG_INDEX_BITS = 2;
	localparam int BYTE_BITS = 8;
	localparam int PC_BITS = 4;

	localparam logic [REG_INDEX_BITS-1:0] REG_MODULUS = 2'd0;
	localparam logic [REG_INDEX_BITS-1:0] REG_PUBLIC_EXPONENT = 2'd1;
	localparam logic [REG_INDEX_BITS-1:0] REG_PRIVATE_EXPONENT = 2'd2;

	localparam logic ACTION_ENCRYPT = 1'b0;
	localparam logic ACTION_DECRYPT = 1'b1;

	typedef struct packed {
		logic action;
		logic [VALUE_BITS-1:0] value;
		logic last_item;
	} item_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] result_value;
		logic last_result;
	} result_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_WAIT,
		OP_REDUCE,
		OP_LOAD_BASE,
		OP_MUL_SETUP,
		OP_MUL_STEP,
		OP_ACC_WRITE,
		OP_SQR_SETUP,
		OP_BASE_WRITE,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_ITEM,
		COND_CNT_NZ,
		COND_EBIT_ZERO,
		COND_ECNT_NZ,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t op;
		cond_t cond;
		logic [PC_BITS-1:0] target;
	} ucode_t;

	localparam logic [PC_BITS-1:0] PC_WAIT = 4'd0;
	localparam logic [PC_BITS-1:0] PC_REDUCE = 4'd1;
	localparam logic [PC_BITS-1:0] PC_LOAD_BASE = 4'd2;
	localparam logic [PC_BITS-1:0] PC_MUL_SETUP = 4'd3;
	localparam logic [PC_BITS-1:0] PC_MUL_STEP = 4'd4;
	localparam logic [PC_BITS-1:0] PC_ACC_WRITE = 4'd5;
	localparam logic [PC_BITS-1:0] PC_SQR_SETUP = 4'd6;
	localparam logic [PC_BITS-1:0] PC_SQR_STEP = 4'd7;
	localparam logic [PC_BITS-1:0] PC_BASE_WRITE = 4'd8;
	localparam logic [PC_BITS-1:0] PC_EMIT = 4'd9;
	localparam logic [PC_BITS-1:0] PC_RETURN = 4'd10;

	// control store: jump to target when the condition holds, else fall through
	function automatic ucode_t ucode_rom(input logic [PC_BITS-1:0] pc);
		ucode_t w;
		case (pc)
			PC_WAIT:       w = '{OP_WAIT, COND_NO_ITEM, PC_WAIT};
			PC_REDUCE:     w = '{OP_REDUCE, COND_CNT_NZ, PC_REDUCE};
			PC_LOAD_BASE:  w = '{OP_LOAD_BASE, COND_NEVER, PC_WAIT};
			PC_MUL_SETUP:  w = '{OP_MUL_SETUP, COND_EBIT_ZERO, PC_SQR_SETUP};
			PC_MUL_STEP:   w = '{OP_MUL_STEP, COND_CNT_NZ, PC_MUL_STEP};
			PC_ACC_WRITE:  w = '{OP_ACC_WRITE, COND_NEVER, PC_WAIT};
			PC_SQR_SETUP:  w = '{OP_SQR_SETUP, COND_NEVER, PC_WAIT};
			PC_SQR_STEP:   w = '{OP_MUL_STEP, COND_CNT_NZ, PC_SQR_STEP};
			PC_BASE_WRITE: w = '{OP_BASE_WRITE, COND_ECNT_NZ, PC_MUL_SETUP};
			PC_EMIT:       w = '{OP_EMIT, COND_OUT_BUSY, PC_EMIT};
			PC_RETURN:     w = '{OP_NOP, COND_ALWAYS, PC_WAIT};
			default:       w = '{OP_NOP, COND_ALWAYS, PC_WAIT};
		endcase
		return w;
	endfunction

endpackage

@@ hdl/rwc_mod_add.sv @@
// (a + b + cin) mod m for a, b below m; the sum keeps its carry bit
module rwc_mod_add #(
	parameter int WORD_BITS = 64
) (
	input  logic [WORD_BITS-1:0] a,
	input  logic [WORD_BITS-1:0] b,
	input  logic                 cin,
	input  logic [WORD_BITS-1:0] m,
	output logic [WORD_BITS-1:0] s
);

	logic [WORD_BITS:0] sum;
	logic [WORD_BITS:0] diff;

	always_comb begin
		sum = {1'b0, a} + {1'b0, b} + {{WORD_BITS{1'b0}}, cin};
		diff = sum - {1'b0, m};
		s = (sum >= {1'b0, m}) ? diff[WORD_BITS-1:0] : sum[WORD_BITS-1:0];
	end

endmodule

@@ hdl/rsa_word_cipher_core.sv @@
// One modular exponentiation per item, run by a small microprogram over a
// shared double-and-add datapath that handles one multiplier bit per cycle.
// The base is first reduced one bit a cycle, all WORD_BITS bits of it; then
// for each of the WORD_BITS exponent bits, lowest first, the accumulator is
// multiplied by the base when the bit is set, and the base is then squared.
// A finished result sits in an output register so the next item is taken
// while it waits. Decrypt returns only the low byte of the residue; a modulus
// below 2 gives a result of 0.
module rsa_word_cipher_core #(
	parameter int WORD_BITS = 64
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    item_valid,
	output logic                                    item_stall,
	input  rwc_pkg::item_t                          item,
	output logic                                    result_valid,
	input  logic                                    result_stall,
	output rwc_pkg::result_t                        result,
	input  logic                                    cfg_we,
	input  logic [rwc_pkg::REG_INDEX_BITS-1:0]      cfg_index,
	input  logic [rwc_pkg::CFG_DATA_BITS-1:0]       cfg_data
);

	localparam int CNT_BITS = $clog2(WORD_BITS);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

	logic [WORD_BITS-1:0] modulus_q;
	logic [WORD_BITS-1:0] public_exponent_q;
	logic [WORD_BITS-1:0] private_exponent_q;

	logic [rwc_pkg::PC_BITS-1:0] pc_q;
	logic [rwc_pkg::PC_BITS-1:0] pc_d;
	rwc_pkg::ucode_t uc;
	logic jump;

	logic [WORD_BITS-1:0] x_q;
	logic [WORD_BITS-1:0] y_q;
	logic [WORD_BITS-1:0] p_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] base_q;
	logic [WORD_BITS-1:0] exp_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [CNT_BITS-1:0] ecnt_q;
	logic action_q;
	logic last_q;

	logic result_valid_q;
	rwc_pkg::result_t result_q;

	logic [WORD_BITS-1:0] add_a;
	logic [WORD_BITS-1:0] add_b;
	logic add_cin;
	logic [WORD_BITS-1:0] sum_p;
	logic [WORD_BITS-1:0] sum_x;

	logic accept;
	logic out_busy;
	logic emit;
	logic [rwc_pkg::VALUE_BITS-1:0] residue;

	assign uc = rwc_pkg::ucode_rom(pc_q);
	assign item_stall = (uc.op != rwc_pkg::OP_WAIT);
	assign accept = item_valid && !item_stall;
	assign out_busy = result_valid_q && result_stall;
	assign emit = (uc.op == rwc_pkg::OP_EMIT) && !out_busy;
	assign result_valid = result_valid_q;
	assign result = result_q;

	always_comb begin
		case (uc.cond)
			rwc_pkg::COND_NEVER:     jump = 1'b0;
			rwc_pkg::COND_ALWAYS:    jump = 1'b1;
			rwc_pkg::COND_NO_ITEM:   jump = !item_valid;
			rwc_pkg::COND_CNT_NZ:    jump = (cnt_q != '0);
			rwc_pkg::COND_EBIT_ZERO: jump = !exp_q[0];
			rwc_pkg::COND_ECNT_NZ:   jump = (ecnt_q != '0);
			rwc_pkg::COND_OUT_BUSY:  jump = out_busy;
			default:                 jump = 1'b0;
		endcase
		pc_d = jump ? uc.target : pc_q + 1'b1;
	end

	// reduction doubles the remainder and shifts in the next base bit
	always_comb begin
		if (uc.op == rwc_pkg::OP_REDUCE) begin
			add_a = p_q;
			add_b = p_q;
			add_cin = y_q[WORD_BITS-1];
		end else begin
			add_a = p_q;
			add_b = x_q;
			add_cin = 1'b0;
		end
	end

	rwc_mod_add #(.WORD_BITS(WORD_BITS)) u_add_acc (
		.a(add_a),
		.b(add_b),
		.cin(add_cin),
		.m(modulus_q),
		.s(sum_p)
	);

	rwc_mod_add #(.WORD_BITS(WORD_BITS)) u_add_dbl (
		.a(x_q),
		.b(x_q),
		.cin(1'b0),
		.m(modulus_q),
		.s(sum_x)
	);

	always_comb begin
		if (modulus_q < WORD_BITS'(2)) begin
			residue = '0;
		end else if (action_q == rwc_pkg::ACTION_DECRYPT) begin
			residue = rwc_pkg::VALUE_BITS'(acc_q[rwc_pkg::BYTE_BITS-1:0]);
		end else begin
			residue = rwc_pkg::VALUE_BITS'(acc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= rwc_pkg::PC_WAIT;
			result_valid_q <= 1'b0;
			modulus_q <= WORD_BITS'(2);
			public_exponent_q <= WORD_BITS'(1);
			private_exponent_q <= WORD_BITS'(1);
		end else begin
			pc_q <= pc_d;
			if (emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					rwc_pkg::REG_MODULUS:          modulus_q <= cfg_data[WORD_BITS-1:0];
					rwc_pkg::REG_PUBLIC_EXPONENT:  public_exponent_q <= cfg_data[WORD_BITS-1:0];
					rwc_pkg::REG_PRIVATE_EXPONENT: private_exponent_q <= cfg_data[WORD_BITS-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (uc.op)
			rwc_pkg::OP_WAIT: begin
				if (accept) begin
					action_q <= item.action;
					last_q <= item.last_item;
					p_q <= '0;
					cnt_q <= CNT_LAST;
					acc_q <= WORD_BITS'(1);
					if (item.action == rwc_pkg::ACTION_DECRYPT) begin
						y_q <= item.value[WORD_BITS-1:0];
						exp_q <= private_exponent_q;
					end else begin
						y_q <= WORD_BITS'(item.value[rwc_pkg::BYTE_BITS-1:0]);
						exp_q <= public_exponent_q;
					end
				end
			end
			rwc_pkg::OP_REDUCE: begin
				p_q <= sum_p;
				y_q <= {y_q[WORD_BITS-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
			end
			rwc_pkg::OP_LOAD_BASE: begin
				base_q <= p_q;
				ecnt_q <= CNT_LAST;
			end
			rwc_pkg::OP_MUL_SETUP: begin
				x_q <= acc_q;
				y_q <= base_q;
				p_q <= '0;
				cnt_q <= CNT_LAST;
			end
			rwc_pkg::OP_MUL_STEP: begin
				if (y_q[0]) begin
					p_q <= sum_p;
				end
				x_q <= sum_x;
				y_q <= {1'b0, y_q[WORD_BITS-1:1]};
				cnt_q <= cnt_q - 1'b1;
			end
			rwc_pkg::OP_ACC_WRITE: begin
				acc_q <= p_q;
			end
			rwc_pkg::OP_SQR_SETUP: begin
				x_q <= base_q;
				y_q <= base_q;
				p_q <= '0;
				cnt_q <= CNT_LAST;
			end
			rwc_pkg::OP_BASE_WRITE: begin
				base_q <= p_q;
				exp_q <= {1'b0, exp_q[WORD_BITS-1:1]};
				ecnt_q <= ecnt_q - 1'b1;
			end
			rwc_pkg::OP_EMIT: begin
				if (emit) begin
					result_q.result_value <= residue;
					result_q.last_result <= last_q;
				end
			end
			default: ;
		endcase
	end

endmodule
